// ===== rtl/tte_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tte_pkg
// Shared widths, constants and types of the tap tempo estimator.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int HISTORY_DEPTH = 8;
  localparam int NUM_GAPS      = HISTORY_DEPTH - 1;
  localparam int TIME_W        = 64;
  localparam int INTERVAL_W    = 32;
  localparam int CNT_W         = $clog2(HISTORY_DEPTH);
  localparam int STORED_W      = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W         = INTERVAL_W + CNT_W;
  localparam int COL_W         = CNT_W + 1;
  localparam int BIT_CNT_W     = $clog2(TIME_W);
  localparam int K_W           = 44;
  localparam int NUM_W         = K_W + CNT_W;
  localparam int DIV_CNT_W     = $clog2(NUM_W);
  localparam int Q_W           = 17;
  localparam int CFG_IDX_W     = 2;

  // 60e9 ns per minute, times 256 for the q8 fraction
  localparam logic [TIME_W-1:0]     K_Q8       = 64'd15360000000000;
  localparam logic [Q_W-1:0]        BPM_Q8_LOW  = 17'd7680;
  localparam logic [Q_W-1:0]        BPM_Q8_HIGH = 17'd76800;
  localparam logic [INTERVAL_W-1:0] MIN_RESET   = 32'd200000000;
  localparam logic [INTERVAL_W-1:0] MAX_RESET   = 32'd3000000000;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP_PREP,
    ST_CMP,
    ST_SUM_PREP,
    ST_SUM,
    ST_DIV_START,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic sum_pass;
    logic sum_en;
  } walk_ctrl_t;

  typedef struct packed {
    logic           done;
    logic           tempo_valid;
    logic [Q_W-1:0] q8;
  } div_res_t;

endpackage
`default_nettype wire

// ===== rtl/tte_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tte_if
// Valid/ready channels of the tap tempo estimator: taps, tempo, register writes.
// ----------------------------------------------------------------------------
interface tte_tap_if import tte_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] tap_time_ns;
  modport source (output valid, output tap_time_ns, input ready);
  modport sink   (input valid, input tap_time_ns, output ready);
endinterface

interface tte_tempo_if import tte_pkg::*; ();
  logic           valid;
  logic           ready;
  logic           tempo_valid;
  logic [Q_W-1:0] tempo_bpm_q8;
  modport source (output valid, output tempo_valid, output tempo_bpm_q8, input ready);
  modport sink   (input valid, input tempo_valid, input tempo_bpm_q8, output ready);
endinterface

interface tte_cfg_if import tte_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [INTERVAL_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/tte_gap_walk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tte_gap_walk
// Tap history as rotating shift registers, bit-serial interval subtract,
// bound compare and column sum of the kept intervals.
// ----------------------------------------------------------------------------
module tte_gap_walk import tte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  tap_load,
  input  logic [TIME_W-1:0]     tap_time,
  input  walk_ctrl_t            ctrl,
  input  logic [INTERVAL_W-1:0] min_interval,
  input  logic [INTERVAL_W-1:0] max_interval,
  output logic [SUM_W-1:0]      sum,
  output logic [CNT_W-1:0]      count
);

  logic [TIME_W-1:0]     hist [HISTORY_DEPTH];
  logic [STORED_W-1:0]   taps_stored;
  logic [INTERVAL_W-1:0] min_sh;
  logic [INTERVAL_W-1:0] max_sh;
  logic [NUM_GAPS-1:0]   borrow;
  logic [NUM_GAPS-1:0]   gt;
  logic [NUM_GAPS-1:0]   lt;
  logic [NUM_GAPS-1:0]   active;
  logic [NUM_GAPS-1:0]   kept;
  logic [NUM_GAPS-1:0]   gap_bit;
  logic [NUM_GAPS-1:0]   borrow_next;
  logic [CNT_W-1:0]      col_carry;
  logic [COL_W-1:0]      col;
  logic [SUM_W-1:0]      sum_sh;
  logic [CNT_W-1:0]      kept_cnt;

  // entry 0 is the newest tap, so gap k is entry k minus entry k+1
  always_comb begin
    for (int k = 0; k < NUM_GAPS; k++) begin
      gap_bit[k]     = hist[k][0] ^ ~hist[k+1][0] ^ borrow[k];
      borrow_next[k] = (hist[k][0] & ~hist[k+1][0]) | (hist[k][0] & borrow[k]) |
                       (~hist[k+1][0] & borrow[k]);
      active[k]      = taps_stored >= STORED_W'(k + 2);
    end
    kept = gt & lt & active;
  end

  always_comb begin
    col      = COL_W'(col_carry);
    kept_cnt = '0;
    for (int k = 0; k < NUM_GAPS; k++) begin
      col      = col + COL_W'(gap_bit[k] & kept[k]);
      kept_cnt = kept_cnt + CNT_W'(kept[k]);
    end
  end

  assign sum   = sum_sh;
  assign count = kept_cnt;

  always_ff @(posedge clk) begin
    if (tap_load) begin
      hist[0] <= tap_time;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist[i] <= hist[i-1];
      end
    end else if (ctrl.step) begin
      // full turn of TIME_W steps leaves every entry as it was
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist[i] <= {hist[i][0], hist[i][TIME_W-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_stored <= '0;
    end else if (tap_load && taps_stored != STORED_W'(HISTORY_DEPTH)) begin
      taps_stored <= taps_stored + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      borrow <= '1;
      if (ctrl.sum_pass) begin
        col_carry <= '0;
        sum_sh    <= '0;
      end else begin
        gt     <= '0;
        lt     <= '0;
        min_sh <= min_interval;
        max_sh <= max_interval;
      end
    end else if (ctrl.step) begin
      borrow <= borrow_next;
      if (ctrl.sum_pass) begin
        col_carry <= col[COL_W-1:1];
        if (ctrl.sum_en) begin
          sum_sh <= {col[0], sum_sh[SUM_W-1:1]};
        end
      end else begin
        // lsb first: a differing higher bit overrides the verdict so far
        for (int k = 0; k < NUM_GAPS; k++) begin
          if (gap_bit[k] != min_sh[0]) gt[k] <= gap_bit[k];
          if (gap_bit[k] != max_sh[0]) lt[k] <= max_sh[0];
        end
        min_sh <= {1'b0, min_sh[INTERVAL_W-1:1]};
        max_sh <= {1'b0, max_sh[INTERVAL_W-1:1]};
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tte_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tte_divider
// Restoring divider, one quotient bit a cycle, with tempo range check.
// ----------------------------------------------------------------------------
module tte_divider import tte_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CNT_W-1:0] count,
  input  logic [SUM_W-1:0] divisor,
  output div_res_t         res
);

  logic [NUM_W-1:0]     num_sh;
  logic [SUM_W-1:0]     rem;
  logic [Q_W-1:0]       quo;
  logic                 ovf;
  logic                 nz;
  logic                 running;
  logic                 done;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SUM_W:0]       shifted;
  logic                 ge;
  logic                 in_range;

  assign shifted  = {rem, num_sh[NUM_W-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign in_range = nz && !ovf && quo >= BPM_Q8_LOW &&
                    (quo < BPM_Q8_HIGH || (quo == BPM_Q8_HIGH && rem == '0));

  assign res.done        = done;
  assign res.tempo_valid = in_range;
  assign res.q8          = in_range ? quo : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= count != '0;
        done    <= count == '0;
      end else if (running && div_cnt == DIV_CNT_W'(NUM_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh  <= NUM_W'(K_Q8 * TIME_W'(count));
      rem     <= '0;
      quo     <= '0;
      ovf     <= 1'b0;
      nz      <= count != '0;
      div_cnt <= '0;
    end else if (running) begin
      rem     <= ge ? SUM_W'(shifted - {1'b0, divisor}) : shifted[SUM_W-1:0];
      quo     <= {quo[Q_W-2:0], ge};
      // a set bit leaving the top means the tempo is far out of range
      ovf     <= ovf | quo[Q_W-1];
      num_sh  <= {num_sh[NUM_W-2:0], 1'b0};
      div_cnt <= div_cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tap_tempo_bpm_estimator_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tap_tempo_bpm_estimator_top
// Tap tempo estimator: BPM in q8 from the intervals of the latest taps.
// ----------------------------------------------------------------------------
// One tap request gives one tempo result, formed in two bit-serial turns of
// the 64-bit tap history (one to compare every interval with the bounds,
// one to add up the kept ones), then a state that forms the numerator, then
// the restoring divider. The next tap is taken as soon as the result sits
// in the output register, even if the sink has not yet taken it. Bound
// registers are written through the cfg channel, index 0 for the lower and
// index 1 for the upper bound; other indices are ignored. A single tap, no
// kept interval, or a tempo outside 30..300 BPM give tempo_valid low and zero.
module tap_tempo_bpm_estimator_top import tte_pkg::*; (
  input logic        clk,
  input logic        rst,
  tte_tap_if.sink    tap,
  tte_tempo_if.source tempo,
  tte_cfg_if.sink    cfg
);

  state_t                state;
  state_t                state_next;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [INTERVAL_W-1:0] min_interval;
  logic [INTERVAL_W-1:0] max_interval;
  logic                  tap_load;
  logic                  div_start;
  logic                  out_load;
  logic                  bit_last;
  walk_ctrl_t            walk_ctrl;
  div_res_t              div_res;
  logic [SUM_W-1:0]      sum;
  logic [CNT_W-1:0]      count;
  logic                  out_valid;
  logic                  out_tempo_valid;
  logic [Q_W-1:0]        out_q8;

  assign cfg.ready = 1'b1;
  assign bit_last  = bit_cnt == BIT_CNT_W'(TIME_W - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_RESET;
      max_interval <= MAX_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MIN_INTERVAL: min_interval <= cfg.data;
        REG_MAX_INTERVAL: max_interval <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (tap.valid) state_next = ST_CMP_PREP;
      ST_CMP_PREP:  state_next = ST_CMP;
      ST_CMP:       if (bit_last) state_next = ST_SUM_PREP;
      ST_SUM_PREP:  state_next = ST_SUM;
      ST_SUM:       if (bit_last) state_next = ST_DIV_START;
      ST_DIV_START: state_next = ST_DIV;
      ST_DIV:       if (div_res.done) state_next = ST_FINISH;
      ST_FINISH:    if (!out_valid || tempo.ready) state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    tap.ready          = 1'b0;
    walk_ctrl          = '0;
    div_start          = 1'b0;
    out_load           = 1'b0;
    unique case (state)
      ST_IDLE:      tap.ready = 1'b1;
      ST_CMP_PREP:  walk_ctrl.clear = 1'b1;
      ST_CMP:       walk_ctrl.step = 1'b1;
      ST_SUM_PREP: begin
        walk_ctrl.clear    = 1'b1;
        walk_ctrl.sum_pass = 1'b1;
      end
      ST_SUM: begin
        walk_ctrl.step     = 1'b1;
        walk_ctrl.sum_pass = 1'b1;
        walk_ctrl.sum_en   = bit_cnt < BIT_CNT_W'(SUM_W);
      end
      ST_DIV_START: div_start = 1'b1;
      ST_DIV:       ;
      ST_FINISH:    out_load = !out_valid || tempo.ready;
    endcase
  end

  assign tap_load = tap.valid && tap.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_ctrl.clear) begin
      bit_cnt <= '0;
    end else if (walk_ctrl.step) begin
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  tte_gap_walk u_walk (
    .clk          (clk),
    .rst          (rst),
    .tap_load     (tap_load),
    .tap_time     (tap.tap_time_ns),
    .ctrl         (walk_ctrl),
    .min_interval (min_interval),
    .max_interval (max_interval),
    .sum          (sum),
    .count        (count)
  );

  tte_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .count   (count),
    .divisor (sum),
    .res     (div_res)
  );

  // output register parts the sink from the walk and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (tempo.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tempo_valid <= div_res.tempo_valid;
      out_q8          <= div_res.q8;
    end
  end

  assign tempo.valid        = out_valid;
  assign tempo.tempo_valid  = out_tempo_valid;
  assign tempo.tempo_bpm_q8 = out_q8;

endmodule
`default_nettype wire
